// ===== src/ttip_pkg.sv =====
// Package for the text-to-integer parser.
// Holds default sizes, register indexes, base and character codes.
// Used by text_to_integer_parser; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ttip_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int INDEX_BITS_DEF = 16;

    localparam int BASE_BITS = 6;
    localparam int CHAR_BITS = 8;

    typedef logic [BASE_BITS-1:0] base_t;
    typedef logic [CHAR_BITS-1:0] char_t;
    typedef logic [0:0]           reg_index_t;

    localparam reg_index_t REG_REQUESTED_BASE = 1'b0;
    localparam reg_index_t REG_SIGNED_MODE    = 1'b1;

    localparam base_t BASE_DETECT = 6'd0;
    localparam base_t BASE_OCT    = 6'd8;
    localparam base_t BASE_DEC    = 6'd10;
    localparam base_t BASE_HEX    = 6'd16;

    localparam char_t CH_NUL   = 8'h00;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_LF    = 8'h0A;
    localparam char_t CH_VT    = 8'h0B;
    localparam char_t CH_FF    = 8'h0C;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_0     = 8'h30;
    localparam char_t CH_9     = 8'h39;
    localparam char_t CH_UA    = 8'h41;
    localparam char_t CH_UZ    = 8'h5A;
    localparam char_t CH_LA    = 8'h61;
    localparam char_t CH_LX    = 8'h78;
    localparam char_t CH_LZ    = 8'h7A;

    localparam char_t LETTER_OFFSET = 8'd10;

endpackage

`default_nettype wire

// ===== src/text_to_integer_parser.sv =====
// Top level of the character-serial text-to-integer parser.
// Contains the input register, the parse state update and the result register.
// Depends on ttip_pkg for sizes, register indexes and character codes.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes one text byte per transfer and returns one result, the value and
// the index of the stopping character, when a string ends or hits a character that is
// not part of the number. It accepts one byte per cycle unless the output stalls. Bytes
// pass the input register, then the parse state; results go to the result register.
// The rate is set by the accumulator update, a multiply by the base and an add of the
// digit, done combinationally. Configuration writes take effect at the next string start
// (base) or result (signed mode) and should be made only while no byte is pending.
module text_to_integer_parser #(
    parameter int VALUE_BITS = ttip_pkg::VALUE_BITS_DEF,
    parameter int INDEX_BITS = ttip_pkg::INDEX_BITS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,

    input  wire                             cfg_wr_en,
    input  wire ttip_pkg::reg_index_t       cfg_index,
    input  wire [ttip_pkg::BASE_BITS-1:0]   cfg_data,

    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire                             s_first_char,
    input  wire [ttip_pkg::CHAR_BITS-1:0]   s_character,

    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [VALUE_BITS-1:0]           m_value,
    output logic [INDEX_BITS-1:0]           m_end_index
);

    localparam int BB = ttip_pkg::BASE_BITS;

    ttip_pkg::base_t  req_base_reg;
    logic             signed_mode_reg;

    logic             in_valid_reg;
    logic             in_first_reg;
    ttip_pkg::char_t  in_char_reg;

    logic [VALUE_BITS-1:0] acc_reg,     acc_next;
    ttip_pkg::base_t       wbase_reg,   wbase_next;
    logic                  minus_reg,   minus_next;
    logic                  content_reg, content_next;
    logic [INDEX_BITS-1:0] pos_reg,     pos_next;
    logic                  active_reg,  active_next;

    logic                  m_valid_reg;
    logic [VALUE_BITS-1:0] m_value_reg, m_value_next;
    logic [INDEX_BITS-1:0] m_index_reg, m_index_next;

    logic                  process_fire;
    logic                  finish;

    logic [VALUE_BITS-1:0] acc_cur;
    ttip_pkg::base_t       wbase_cur;
    logic                  minus_cur;
    logic                  content_cur;
    logic [INDEX_BITS-1:0] pos_cur;
    logic                  active_cur;
    logic [INDEX_BITS-1:0] pos_inc;
    ttip_pkg::base_t       digit;
    logic                  is_digit;
    logic                  is_blank;
    logic                  acc_zero;
    logic [VALUE_BITS+BB-1:0] product;
    logic [VALUE_BITS-1:0] acc_mac;

    assign process_fire = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready      = !in_valid_reg || process_fire;
    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_end_index  = m_index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_base_reg    <= ttip_pkg::BASE_DEC;
            signed_mode_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ttip_pkg::REG_REQUESTED_BASE: req_base_reg    <= cfg_data;
                ttip_pkg::REG_SIGNED_MODE:    signed_mode_reg <= cfg_data[0];
                default:                      req_base_reg    <= req_base_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_first_reg <= s_first_char;
            in_char_reg  <= s_character;
        end
    end

    always_comb begin
        if (in_first_reg) begin
            acc_cur     = '0;
            wbase_cur   = req_base_reg;
            minus_cur   = 1'b0;
            content_cur = 1'b0;
            pos_cur     = '0;
            active_cur  = 1'b1;
        end else begin
            acc_cur     = acc_reg;
            wbase_cur   = wbase_reg;
            minus_cur   = minus_reg;
            content_cur = content_reg;
            pos_cur     = pos_reg;
            active_cur  = active_reg;
        end
    end

    assign pos_inc  = (&pos_cur) ? pos_cur : pos_cur + INDEX_BITS'(1);
    assign acc_zero = (acc_cur == '0);
    assign is_blank = in_char_reg inside {ttip_pkg::CH_SPACE, ttip_pkg::CH_TAB,
                                          ttip_pkg::CH_LF, ttip_pkg::CH_VT,
                                          ttip_pkg::CH_FF, ttip_pkg::CH_CR};

    always_comb begin
        acc_next     = acc_cur;
        wbase_next   = wbase_cur;
        minus_next   = minus_cur;
        content_next = content_cur;
        pos_next     = pos_cur;
        active_next  = active_cur;
        finish       = 1'b0;
        digit        = '0;
        is_digit     = 1'b0;
        product      = '0;
        acc_mac      = '0;

        if (active_cur) begin
            if (in_char_reg == ttip_pkg::CH_NUL) begin
                finish = 1'b1;
            end else if (in_char_reg == ttip_pkg::CH_PLUS ||
                         in_char_reg == ttip_pkg::CH_MINUS) begin
                content_next = 1'b1;
                minus_next   = minus_cur || (in_char_reg == ttip_pkg::CH_MINUS);
                pos_next     = pos_inc;
            end else begin
                if (in_char_reg inside {[ttip_pkg::CH_0 : ttip_pkg::CH_9]}) begin
                    is_digit = 1'b1;
                    digit    = BB'(in_char_reg - ttip_pkg::CH_0);
                    if (in_char_reg == ttip_pkg::CH_0 && acc_zero &&
                        wbase_cur == ttip_pkg::BASE_DETECT) begin
                        wbase_next = ttip_pkg::BASE_OCT;
                    end
                end else if (in_char_reg inside {[ttip_pkg::CH_UA : ttip_pkg::CH_UZ]}) begin
                    is_digit = 1'b1;
                    digit    = BB'(in_char_reg - ttip_pkg::CH_UA + ttip_pkg::LETTER_OFFSET);
                end else if (in_char_reg == ttip_pkg::CH_LX && acc_zero &&
                             wbase_cur inside {ttip_pkg::BASE_DETECT, ttip_pkg::BASE_OCT,
                                               ttip_pkg::BASE_HEX}) begin
                    is_digit   = 1'b1;
                    digit      = '0;
                    wbase_next = ttip_pkg::BASE_HEX;
                end else if (in_char_reg inside {[ttip_pkg::CH_LA : ttip_pkg::CH_LZ]}) begin
                    is_digit = 1'b1;
                    digit    = BB'(in_char_reg - ttip_pkg::CH_LA + ttip_pkg::LETTER_OFFSET);
                end

                if (!is_digit) begin
                    if (is_blank && !content_cur) begin
                        pos_next = pos_inc;
                    end else begin
                        finish = 1'b1;
                    end
                end else begin
                    content_next = 1'b1;
                    if (digit != '0 && wbase_next == ttip_pkg::BASE_DETECT) begin
                        wbase_next = ttip_pkg::BASE_DEC;
                    end
                    if (digit < wbase_next) begin
                        product  = {{BB{1'b0}}, acc_cur} * {{VALUE_BITS{1'b0}}, wbase_next};
                        acc_mac  = product[VALUE_BITS-1:0] + VALUE_BITS'(digit);
                        acc_next = acc_mac;
                        pos_next = pos_inc;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
        end

        if (finish) begin
            active_next = 1'b0;
        end
    end

    always_comb begin
        m_index_next = pos_cur;
        if (signed_mode_reg && minus_cur) begin
            m_value_next = ~acc_cur + VALUE_BITS'(1);
        end else begin
            m_value_next = acc_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            wbase_reg   <= ttip_pkg::BASE_DEC;
            minus_reg   <= 1'b0;
            content_reg <= 1'b0;
            pos_reg     <= '0;
            active_reg  <= 1'b0;
        end else if (process_fire) begin
            acc_reg     <= acc_next;
            wbase_reg   <= wbase_next;
            minus_reg   <= minus_next;
            content_reg <= content_next;
            pos_reg     <= pos_next;
            active_reg  <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (process_fire) begin
            m_valid_reg <= finish;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (process_fire && finish) begin
            m_value_reg <= m_value_next;
            m_index_reg <= m_index_next;
        end
    end

`ifndef SYNTHESIS
    // A result can only come from a parse that is running or starts with this byte.
    a_finish_needs_parse: assert property (@(posedge aclk) disable iff (!aresetn)
        (process_fire && finish) |-> (active_reg || in_first_reg))
        else $error("result produced while no parse was active");

    // A result ends the parse.
    a_finish_ends_parse: assert property (@(posedge aclk) disable iff (!aresetn)
        (process_fire && finish) |=> !active_reg)
        else $error("parse still active after its result");

    // A byte held in the input register is not lost or overwritten while stalled.
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !process_fire) |=> (in_valid_reg && $stable(in_char_reg)))
        else $error("pending input byte lost during a stall");

    // The first byte of a string leaves the position at zero or one.
    a_start_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (process_fire && in_first_reg) |=> (pos_reg == '0 || pos_reg == INDEX_BITS'(1)))
        else $error("position not restarted at string start");
`endif

endmodule

`default_nettype wire
